>>> rtl/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg
// Shared types and constants for the affine vertex transform.
// ----------------------------------------------------------------------------
package avt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int N_CELLS   = 16;
    localparam int IDX_W     = 4;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;

    localparam t_word FIX_ONE = t_word'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_POINT = 2'd1,
        OP_DIR   = 2'd2
    } t_opcode;

    typedef struct packed {
        logic  en;
        t_idx  idx;
        t_word value;
    } t_cell_wr;

endpackage

>>> rtl/avt_matrix.sv
// ----------------------------------------------------------------------------
// avt_matrix
// 4x4 matrix store, row-major. Resets to identity; one cell write per cycle.
// ----------------------------------------------------------------------------
module avt_matrix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  avt_pkg::t_cell_wr i_wr,
    output avt_pkg::t_word   o_cells [avt_pkg::N_CELLS]
);
    import avt_pkg::*;

    t_word r_cell [N_CELLS];

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        localparam bit   DIAG = ((g % 5) == 0);
        localparam t_idx IDX  = t_idx'(g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cell[g] <= DIAG ? FIX_ONE : '0;
            end else if (i_wr.en && (i_wr.idx == IDX)) begin
                r_cell[g] <= i_wr.value;
            end
        end

        assign o_cells[g] = r_cell[g];
    end

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> r_cell[$past(i_wr.idx)] == $past(i_wr.value))
        else $error("matrix cell write lost");

    a_reset_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_cell[0] == FIX_ONE) && (r_cell[5] == FIX_ONE)
                            && (r_cell[1] == '0) && (r_cell[15] == FIX_ONE))
        else $error("matrix not identity after reset");

    a_row3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.en && (i_wr.idx == t_idx'(15))) |=> $stable(r_cell[15]))
        else $error("unwritten cell changed");

endmodule

>>> rtl/affine_vertex_transform.sv
// ----------------------------------------------------------------------------
// affine_vertex_transform
// Pipeline: an accepted item passes the input register, the product register
// and the result register; o_valid is the result register's valid bit.
// Throughput: one item per cycle while i_stall does not hold the pipeline.
// Cell writes produce no result and apply to every item accepted after them.
// Reset (synchronous, active low) empties the pipeline and loads identity.
// ----------------------------------------------------------------------------
module affine_vertex_transform (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_opcode,
    input  avt_pkg::t_idx  i_cell_index,
    input  avt_pkg::t_word i_cell_value,
    input  avt_pkg::t_word i_vec_x,
    input  avt_pkg::t_word i_vec_y,
    input  avt_pkg::t_word i_vec_z,
    output logic           o_valid,
    input  logic           i_stall,
    output avt_pkg::t_word o_out_x,
    output avt_pkg::t_word o_out_y,
    output avt_pkg::t_word o_out_z
);
    import avt_pkg::*;

    function automatic t_word fx_mul(input t_word a, input t_word b);
        logic signed [2*WORD_W-1:0] p;
        p = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        return p[FRAC_BITS +: WORD_W];
    endfunction

    t_word    m [N_CELLS];
    t_cell_wr wr;

    logic s1_rdy, s2_rdy, s3_rdy, in_acc;
    logic is_write, is_xform, is_point;

    logic  r_s1_valid, r_s1_point;
    t_word r_s1_vec [3];

    logic  r_s2_valid;
    t_word r_s2_prod [3][3];
    t_word r_s2_add  [3];

    logic  r_s3_valid;
    t_word r_s3_out [3];

    always_comb begin
        is_write = 1'b0;
        is_xform = 1'b0;
        is_point = 1'b0;
        case (t_opcode'(i_opcode))
            OP_WRITE: is_write = 1'b1;
            OP_POINT: begin
                is_xform = 1'b1;
                is_point = 1'b1;
            end
            OP_DIR:   is_xform = 1'b1;
            default:  ;
        endcase
    end

    assign s3_rdy  = !r_s3_valid || !i_stall;
    assign s2_rdy  = !r_s2_valid || s3_rdy;
    assign s1_rdy  = !r_s1_valid || s2_rdy;
    assign o_stall = !s1_rdy;
    assign in_acc  = i_valid && s1_rdy;

    // Write lands at the same edge where any older item captures its products.
    assign wr.en    = in_acc && is_write;
    assign wr.idx   = i_cell_index;
    assign wr.value = i_cell_value;

    avt_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_cells (m)
    );

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_valid <= in_acc && is_xform;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_point  <= is_point;
            r_s1_vec[0] <= i_vec_x;
            r_s1_vec[1] <= i_vec_y;
            r_s1_vec[2] <= i_vec_z;
        end
    end

    // Stage 2: nine products, translation column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s2_prod[r][c] <= fx_mul(r_s1_vec[c], m[r*4 + c]);
                end
                r_s2_add[r] <= r_s1_point ? m[r*4 + 3] : '0;
            end
        end
    end

    // Stage 3: wrapping sums into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_rdy) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy && r_s2_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_s3_out[r] <= r_s2_prod[r][0] + r_s2_prod[r][1]
                             + r_s2_prod[r][2] + r_s2_add[r];
            end
        end
    end

    assign o_valid = r_s3_valid;
    assign o_out_x = r_s3_out[0];
    assign o_out_y = r_s3_out[1];
    assign o_out_z = r_s3_out[2];

    a_xform_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_xform) |=> r_s1_valid)
        else $error("accepted transform missing from stage 1");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_rdy) |=> r_s2_valid && $stable(r_s2_add[0])
                                    && $stable(r_s2_prod[0][0]))
        else $error("stalled product stage changed");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_s2_valid && !r_s3_valid) |-> !o_stall)
        else $error("stall raised with empty pipeline");

endmodule
